// ===== src/tsd_pkg.sv =====
// Shared types, constants and AES helper functions for the transport stream descrambler.
package tsd_pkg;

  localparam int PACKET_BYTES = 188;
  localparam int BLOCK_BYTES  = 16;
  localparam int AES_ROUNDS   = 10;

  localparam logic [7:0]  SYNC_BYTE = 8'h47;
  localparam logic [12:0] NULL_PID  = 13'h1FFF;

  localparam logic [2:0] CLS_CLEAR   = 3'd0;
  localparam logic [2:0] CLS_DESCR   = 3'd1;
  localparam logic [2:0] CLS_NULL    = 3'd2;
  localparam logic [2:0] CLS_BADSYNC = 3'd3;
  localparam logic [2:0] CLS_BADOFF  = 3'd4;

  localparam logic [2:0] REG_KEY_HIGH      = 3'd0;
  localparam logic [2:0] REG_KEY_LOW       = 3'd1;
  localparam logic [2:0] REG_IV_HIGH       = 3'd2;
  localparam logic [2:0] REG_IV_LOW        = 3'd3;
  localparam logic [2:0] REG_IV_PER_PACKET = 3'd4;

  localparam logic [127:0] KEY_RESET = {2{64'h1111111111111111}};

  typedef struct packed {
    logic        we;
    logic [2:0]  index;
    logic [63:0] data;
  } tsd_cfg_t;

  typedef struct packed {
    logic [4:0] cnt;     // bytes in the item, 1 to 16
    logic       dec;     // block to be decrypted
    logic [2:0] status;
    logic       done;    // last byte closes the packet
  } tsd_meta_t;

  typedef struct packed {
    logic [127:0] data;  // byte 0 in the top bits
    logic [127:0] chain;
    tsd_meta_t    meta;
  } tsd_entry_t;

  localparam logic [7:0] SBOX_TBL [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX_TBL [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] rcon(input logic [3:0] idx);
    logic [7:0] r;
    unique case (idx)
      4'd0: r = 8'h01;
      4'd1: r = 8'h02;
      4'd2: r = 8'h04;
      4'd3: r = 8'h08;
      4'd4: r = 8'h10;
      4'd5: r = 8'h20;
      4'd6: r = 8'h40;
      4'd7: r = 8'h80;
      4'd8: r = 8'h1b;
      4'd9: r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // RotWord then SubWord, rcon folded into the top byte
  function automatic logic [31:0] sub_rot(input logic [31:0] w, input logic [7:0] rc);
    logic [31:0] r;
    r = {SBOX_TBL[w[23:16]] ^ rc, SBOX_TBL[w[15:8]], SBOX_TBL[w[7:0]], SBOX_TBL[w[31:24]]};
    return r;
  endfunction

  // round key r from round key r-1
  function automatic logic [127:0] rk_next(input logic [127:0] rk, input logic [3:0] r);
    logic [31:0] n0, n1, n2, n3;
    n0 = rk[127:96] ^ sub_rot(rk[31:0], rcon(r - 4'd1));
    n1 = n0 ^ rk[95:64];
    n2 = n1 ^ rk[63:32];
    n3 = n2 ^ rk[31:0];
    return {n0, n1, n2, n3};
  endfunction

  // round key r-1 from round key r
  function automatic logic [127:0] rk_prev(input logic [127:0] rk, input logic [3:0] r);
    logic [31:0] q0, q1, q2, q3;
    q3 = rk[31:0] ^ rk[63:32];
    q2 = rk[63:32] ^ rk[95:64];
    q1 = rk[95:64] ^ rk[127:96];
    q0 = rk[127:96] ^ sub_rot(q3, rcon(r - 4'd1));
    return {q0, q1, q2, q3};
  endfunction

  function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
    logic [127:0] t;
    int src;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = 4 * ((c + 4 - r) % 4) + r;
        t[127 - 8 * (4 * c + r) -: 8] = INV_SBOX_TBL[s[127 - 8 * src -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] inv_mix_col(input logic [31:0] col);
    logic [7:0] a [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    logic [7:0] x2, x4, x8;
    for (int i = 0; i < 4; i++) begin
      a[i]  = col[31 - 8 * i -: 8];
      x2    = xt(a[i]);
      x4    = xt(x2);
      x8    = xt(x4);
      m9[i] = x8 ^ a[i];
      mb[i] = x8 ^ x2 ^ a[i];
      md[i] = x8 ^ x4 ^ a[i];
      me[i] = x8 ^ x4 ^ x2;
    end
    return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
            m9[0] ^ me[1] ^ mb[2] ^ md[3],
            md[0] ^ m9[1] ^ me[2] ^ mb[3],
            mb[0] ^ md[1] ^ m9[2] ^ me[3]};
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      t[127 - 32 * c -: 32] = inv_mix_col(s[127 - 32 * c -: 32]);
    end
    return t;
  endfunction

endpackage

// ===== src/tsd_key_sched.sv =====
// Key registers and forward key expansion up to the last round key.
module tsd_key_sched (
  input  logic             clk,
  input  logic             rst,
  input  tsd_pkg::tsd_cfg_t cfg,
  output logic             busy,
  output logic [127:0]     rk_last
);
  import tsd_pkg::*;

  logic [127:0] key;
  logic [127:0] cur;
  logic [3:0]   cnt;

  assign rk_last = cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      key  <= KEY_RESET;
      busy <= 1'b1;
      cnt  <= 4'd0;
    end else if (cfg.we && (cfg.index == REG_KEY_HIGH || cfg.index == REG_KEY_LOW)) begin
      if (cfg.index == REG_KEY_HIGH) begin
        key[127:64] <= cfg.data;
      end else begin
        key[63:0] <= cfg.data;
      end
      busy <= 1'b1;
      cnt  <= 4'd0;
    end else if (busy) begin
      if (cnt == 4'd0) begin
        cur <= key;
        cnt <= 4'd1;
      end else begin
        cur <= rk_next(cur, cnt);
        if (cnt == 4'(AES_ROUNDS)) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt + 4'd1;
        end
      end
    end
  end

endmodule

// ===== src/tsd_front.sv =====
// Front end: packet position, header classification, block collection and CBC chaining.
module tsd_front (
  input  logic              clk,
  input  logic              rst,
  input  tsd_pkg::tsd_cfg_t cfg,
  input  logic              in_acc,
  input  logic [7:0]        in_byte,
  output logic              push,
  output tsd_pkg::tsd_entry_t entry
);
  import tsd_pkg::*;

  logic [7:0]   pos;
  logic [2:0]   cls;
  logic [7:0]   ps;
  logic [7:0]   hdr [4];
  logic [127:0] blk;
  logic [127:0] chain;
  logic [63:0]  iv_hi, iv_lo;
  logic         per_packet;

  logic [12:0]  pid;
  logic [8:0]   off;
  logic [2:0]   cls_c, cls_e;
  logic [7:0]   ps_e, span, enc_end, diff;
  logic [3:0]   k;
  logic         is_hdr, in_blk;
  logic [127:0] cipher;
  logic [7:0]   hdr3_out;

  always_comb begin
    pid = {hdr[1][4:0], hdr[2]};
    off = hdr[3][5] ? (9'(in_byte) + 9'd5) : 9'd4;
    priority if (hdr[0] != SYNC_BYTE) cls_c = CLS_BADSYNC;
    else if (pid == NULL_PID)         cls_c = CLS_NULL;
    else if (hdr[3][7:6] == 2'b00)    cls_c = CLS_CLEAR;
    else if (off > 9'(PACKET_BYTES))  cls_c = CLS_BADOFF;
    else                              cls_c = CLS_DESCR;

    is_hdr   = (pos == 8'd4);
    cls_e    = is_hdr ? cls_c : cls;
    ps_e     = (is_hdr && cls_c == CLS_DESCR) ? off[7:0] : ps;
    span     = 8'(PACKET_BYTES) - ps_e;
    enc_end  = ps_e + (span & ~8'(BLOCK_BYTES - 1));
    in_blk   = (cls_e == CLS_DESCR) && (pos >= ps_e) && (pos < enc_end);
    diff     = pos - ps_e;
    k        = diff[3:0];
    cipher   = {blk[127:8], in_byte};
    hdr3_out = (cls_c == CLS_DESCR) ? (hdr[3] & 8'h3f) : hdr[3];

    // the header item always leaves at byte 4, even when that byte opens a block
    push = in_acc && (pos >= 8'd4) && (is_hdr || !in_blk || k == 4'hf);

    entry.chain       = chain;
    entry.meta.status = cls_e;
    entry.meta.done   = (pos == 8'(PACKET_BYTES - 1));
    if (is_hdr) begin
      entry.data     = {hdr[0], hdr[1], hdr[2], hdr3_out, in_byte, 88'd0};
      entry.meta.cnt = in_blk ? 5'd4 : 5'd5;
      entry.meta.dec = 1'b0;
    end else if (in_blk) begin
      entry.data     = cipher;
      entry.meta.cnt = 5'(BLOCK_BYTES);
      entry.meta.dec = 1'b1;
    end else begin
      entry.data     = {in_byte, 120'd0};
      entry.meta.cnt = 5'd1;
      entry.meta.dec = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= 8'd0;
      cls        <= CLS_CLEAR;
      ps         <= 8'd0;
      chain      <= 128'd0;
      iv_hi      <= 64'd0;
      iv_lo      <= 64'd0;
      per_packet <= 1'b0;
    end else begin
      if (cfg.we) begin
        if (cfg.index == REG_IV_HIGH) begin
          iv_hi         <= cfg.data;
          chain[127:64] <= cfg.data;
        end
        if (cfg.index == REG_IV_LOW) begin
          iv_lo       <= cfg.data;
          chain[63:0] <= cfg.data;
        end
        if (cfg.index == REG_IV_PER_PACKET) begin
          per_packet <= cfg.data[0];
        end
      end
      if (in_acc) begin
        pos <= (pos == 8'(PACKET_BYTES - 1)) ? 8'd0 : pos + 8'd1;
        if (pos < 8'd4) begin
          hdr[pos[1:0]] <= in_byte;
        end
        if (is_hdr) begin
          cls <= cls_c;
          if (cls_c == CLS_DESCR) begin
            ps <= off[7:0];
            if (per_packet) begin
              chain <= {iv_hi, iv_lo};
            end
          end
        end
        if (in_blk) begin
          blk[{~k, 3'b000} +: 8] <= in_byte;
          if (k == 4'hf) begin
            chain <= cipher;
          end
        end
      end
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos < 8'(PACKET_BYTES))
    else $error("packet position out of range");

  a_block_whole: assert property (@(posedge clk) disable iff (rst)
    (push && entry.meta.dec) |-> (diff[3:0] == 4'hf && ps <= 8'(PACKET_BYTES)))
    else $error("block issued before it was complete");

endmodule

// ===== src/tsd_queue.sv =====
// Short queue between front and back ends.
module tsd_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tsd_pkg::tsd_entry_t wr_entry,
  input  logic                pop,
  output logic                full,
  output logic                rd_valid,
  output tsd_pkg::tsd_entry_t rd_entry
);
  import tsd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tsd_entry_t    slots [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_entry = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
      end
      if (pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("queue written while full");

endmodule

// ===== src/tsd_back.sv =====
// Back end: iterative AES-128 decryption core and byte serialiser with output register.
module tsd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic [127:0]        rk_last,
  input  logic                q_valid,
  input  tsd_pkg::tsd_entry_t q_entry,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                out_decrypted,
  output logic                out_last,
  output logic                packet_done,
  output logic [2:0]          packet_status
);
  import tsd_pkg::*;

  logic         a_valid, a_done;
  logic [3:0]   a_rr;
  logic [127:0] a_state, a_rk, a_chain;
  tsd_meta_t    a_meta;

  logic [127:0] s_buf;
  logic [4:0]   s_cnt;
  tsd_meta_t    s_meta;

  logic         out_acc, b_free, a_xfer;
  logic [127:0] nk, t;

  assign out_acc = out_valid && !out_stall;
  assign b_free  = (s_cnt == 5'd0) || (s_cnt == 5'd1 && out_acc);
  assign a_xfer  = a_valid && a_done && b_free;
  assign pop     = q_valid && (!a_valid || a_xfer);

  assign nk = rk_prev(a_rk, a_rr);
  assign t  = inv_shift_sub(a_state) ^ nk;

  assign out_valid     = (s_cnt != 5'd0);
  assign out_byte      = s_buf[127:120];
  assign out_decrypted = s_meta.dec;
  assign out_last      = (s_cnt == 5'd1);
  assign packet_done   = s_meta.done && (s_cnt == 5'd1);
  assign packet_status = s_meta.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      a_done  <= 1'b0;
      s_cnt   <= 5'd0;
    end else begin
      if (pop) begin
        a_valid <= 1'b1;
        a_meta  <= q_entry.meta;
        a_chain <= q_entry.chain;
        a_rr    <= 4'(AES_ROUNDS);
        a_rk    <= rk_last;
        if (q_entry.meta.dec) begin
          a_state <= q_entry.data ^ rk_last;
          a_done  <= 1'b0;
        end else begin
          a_state <= q_entry.data;
          a_done  <= 1'b1;
        end
      end else if (a_xfer) begin
        a_valid <= 1'b0;
      end else if (a_valid && !a_done) begin
        a_rk <= nk;
        a_rr <= a_rr - 4'd1;
        if (a_rr == 4'd1) begin
          // last round has no column mix; CBC xor folds in here
          a_state <= t ^ a_chain;
          a_done  <= 1'b1;
        end else begin
          a_state <= inv_mix(t);
        end
      end

      if (a_xfer) begin
        s_buf  <= a_state;
        s_cnt  <= a_meta.cnt;
        s_meta <= a_meta;
      end else if (out_acc) begin
        s_buf <= {s_buf[119:0], 8'd0};
        s_cnt <= s_cnt - 5'd1;
      end
    end
  end

  a_round_live: assert property (@(posedge clk) disable iff (rst)
    (a_valid && !a_done) |-> (a_rr != 4'd0))
    else $error("decryption running past round zero");

  a_ser_count: assert property (@(posedge clk) disable iff (rst)
    s_cnt <= 5'(BLOCK_BYTES))
    else $error("serialiser count too large");

  a_hold_done: assert property (@(posedge clk) disable iff (rst)
    (a_valid && a_done && !b_free) |=> (a_valid && a_done))
    else $error("finished item lost before hand-over");

endmodule

// ===== src/ts_aes_cbc_descrambler_unit.sv =====
// Top level of the MPEG transport stream AES-128 CBC payload descrambler.
// One stream byte is accepted per cycle while in_stall is low and result bytes leave one
// per cycle while out_stall is low, so the sustained rate is one byte per cycle in both
// directions. Header bytes 0 to 3 produce nothing until byte 4 arrives; a whole 16-byte
// payload block leaves as a run of 16 bytes once its last byte is in. Each block is
// decrypted in the iterative AES core (one inverse round per cycle, round keys derived
// backwards on the fly), overlapped with the output of the previous run, so back-to-back
// blocks 16 bytes apart never starve the output. After reset and after any key write
// the input stalls while the key schedule is run forward to the last round key. A queue
// of QUEUE_DEPTH items lets the input keep flowing while the output side is stalled.
module ts_aes_cbc_descrambler_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_decrypted,
  output logic        out_last,
  output logic        packet_done,
  output logic [2:0]  packet_status
);
  import tsd_pkg::*;

  tsd_cfg_t     cfg;
  tsd_entry_t   f_entry, q_entry;
  logic         f_push, q_full, q_valid, q_pop, ks_busy, in_acc;
  logic [127:0] rk_last;

  assign cfg      = '{we: cfg_we, index: cfg_index, data: cfg_data};
  assign in_stall = q_full || ks_busy;
  assign in_acc   = in_valid && !in_stall;

  tsd_key_sched u_key (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .busy    (ks_busy),
    .rk_last (rk_last)
  );

  tsd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_acc  (in_acc),
    .in_byte (in_byte),
    .push    (f_push),
    .entry   (f_entry)
  );

  tsd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (f_push),
    .wr_entry (f_entry),
    .pop      (q_pop),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_entry (q_entry)
  );

  tsd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .rk_last       (rk_last),
    .q_valid       (q_valid),
    .q_entry       (q_entry),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_decrypted (out_decrypted),
    .out_last      (out_last),
    .packet_done   (packet_done),
    .packet_status (packet_status)
  );

endmodule

// ===== verif/ts_aes_cbc_descrambler_checker.sv =====
// Checker for the descrambler: predicts every output item and compares it as it leaves.
`timescale 1ns / 100ps
module ts_aes_cbc_descrambler_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic        out_decrypted,
  input  logic        out_last,
  input  logic        packet_done,
  input  logic [2:0]  packet_status,
  output int          errors,
  output int          pending
);
  import tsd_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       dec;
    logic       last;
    logic       done;
    logic [2:0] status;
  } ts_out_item_t;

  ts_out_item_t   expected_bytes [$];
  logic [63:0]    key_hi, key_lo, iv_hi, iv_lo;
  logic           iv_reload;
  int             pos, pstart;
  logic [2:0]     pkt_class;
  logic [7:0]     fill [16];
  logic [127:0]   chain;
  logic [31:0]    rkw [44];
  logic [7:0]     inv_sb [256];

  initial begin
    errors = 0;
    for (int i = 0; i < 256; i++) inv_sb[SBOX_TBL[i]] = i[7:0];
  end

  assign pending = expected_bytes.size();

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return r;
  endfunction

  task automatic expand_keys();
    logic [31:0] t;
    rkw[0] = key_hi[63:32];
    rkw[1] = key_hi[31:0];
    rkw[2] = key_lo[63:32];
    rkw[3] = key_lo[31:0];
    for (int i = 4; i < 44; i++) begin
      t = rkw[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {SBOX_TBL[t[31:24]], SBOX_TBL[t[23:16]], SBOX_TBL[t[15:8]], SBOX_TBL[t[7:0]]};
        t[31:24] ^= (i / 4 <= 8) ? (8'h01 << (i / 4 - 1)) : ((i / 4 == 9) ? 8'h1b : 8'h36);
      end
      rkw[i] = rkw[i-4] ^ t;
    end
  endtask

  // state byte i (column i/4, row i%4) lives at bits 127-8i
  function automatic logic [127:0] add_round(input logic [127:0] s, input int rnd);
    for (int c = 0; c < 4; c++) s[127 - 32 * c -: 32] ^= rkw[4 * rnd + c];
    return s;
  endfunction

  function automatic logic [127:0] unshift_unsub(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127 - 8 * (4 * c + r) -: 8] = inv_sb[s[127 - 8 * (4 * ((c + 4 - r) % 4) + r) -: 8]];
    return t;
  endfunction

  function automatic logic [127:0] unmix(input logic [127:0] s);
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      {a0, a1, a2, a3} = s[127 - 32 * c -: 32];
      t[127 - 32 * c -: 32] = {
        gf_mul(a0, 14) ^ gf_mul(a1, 11) ^ gf_mul(a2, 13) ^ gf_mul(a3, 9),
        gf_mul(a0, 9) ^ gf_mul(a1, 14) ^ gf_mul(a2, 11) ^ gf_mul(a3, 13),
        gf_mul(a0, 13) ^ gf_mul(a1, 9) ^ gf_mul(a2, 14) ^ gf_mul(a3, 11),
        gf_mul(a0, 11) ^ gf_mul(a1, 13) ^ gf_mul(a2, 9) ^ gf_mul(a3, 14)};
    end
    return t;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic dec, input int p);
    ts_out_item_t e;
    e.data = b;
    e.dec = dec;
    e.last = 1'b0;
    e.done = (p == PACKET_BYTES - 1);
    e.status = pkt_class;
    expected_bytes.push_back(e);
  endtask

  task automatic descramble_byte(input logic [7:0] b);
    int p, ps, span, enc_end, k, off, n0;
    logic [12:0] pid;
    logic [7:0] h;
    logic [127:0] ct, s;
    p = (pos >= PACKET_BYTES) ? 0 : pos;
    n0 = expected_bytes.size();
    if (p < 4) begin
      fill[p] = b;
    end else begin
      if (p == 4) begin
        pid = {fill[1][4:0], fill[2]};
        if (fill[0] != SYNC_BYTE) pkt_class = CLS_BADSYNC;
        else if (pid == NULL_PID) pkt_class = CLS_NULL;
        else if (fill[3][7:6] == 2'b00) pkt_class = CLS_CLEAR;
        else begin
          off = 4 + (fill[3][5] ? b + 1 : 0);
          if (off > PACKET_BYTES) pkt_class = CLS_BADOFF;
          else begin
            pkt_class = CLS_DESCR;
            pstart = off;
            if (iv_reload) chain = {iv_hi, iv_lo};
          end
        end
        for (int i = 0; i < 4; i++) begin
          h = fill[i];
          if (i == 3 && pkt_class == CLS_DESCR) h[7:6] = 2'b00;
          push_byte(h, 1'b0, i);
        end
      end
      ps = (pstart > PACKET_BYTES) ? PACKET_BYTES : pstart;
      span = PACKET_BYTES - ps;
      enc_end = ps + span - span % BLOCK_BYTES;
      if (pkt_class != CLS_DESCR || p < ps || p >= enc_end) begin
        push_byte(b, 1'b0, p);
      end else begin
        k = (p - ps) % BLOCK_BYTES;
        fill[k] = b;
        if (k == BLOCK_BYTES - 1) begin
          for (int i = 0; i < 16; i++) ct[127 - 8 * i -: 8] = fill[i];
          s = add_round(ct, 10);
          for (int r = 9; r >= 1; r--) s = unmix(add_round(unshift_unsub(s), r));
          s = add_round(unshift_unsub(s), 0) ^ chain;
          chain = ct;
          for (int i = 0; i < 16; i++) push_byte(s[127 - 8 * i -: 8], 1'b1, p - 15 + i);
        end
      end
    end
    pos = (p + 1 >= PACKET_BYTES) ? 0 : p + 1;
    if (expected_bytes.size() > n0) expected_bytes[$].last = 1'b1;
  endtask

  task automatic check_byte();
    ts_out_item_t e;
    if (expected_bytes.size() == 0) begin
      $error("output item with nothing expected: byte %h", out_byte);
      errors++;
    end else begin
      e = expected_bytes.pop_front();
      if (out_byte !== e.data) begin
        $error("out_byte: expected %h, got %h", e.data, out_byte); errors++;
      end
      if (out_decrypted !== e.dec) begin
        $error("out_decrypted: expected %b, got %b", e.dec, out_decrypted); errors++;
      end
      if (out_last !== e.last) begin
        $error("out_last: expected %b, got %b", e.last, out_last); errors++;
      end
      if (packet_done !== e.done) begin
        $error("packet_done: expected %b, got %b", e.done, packet_done); errors++;
      end
      if (packet_status !== e.status) begin
        $error("packet_status: expected %0d, got %0d", e.status, packet_status); errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      key_hi = 64'h1111111111111111;
      key_lo = 64'h1111111111111111;
      iv_hi = '0;
      iv_lo = '0;
      iv_reload = 1'b0;
      pos = 0;
      pstart = 0;
      pkt_class = CLS_CLEAR;
      chain = '0;
      expand_keys();
      expected_bytes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY_HIGH: begin key_hi = cfg_data; expand_keys(); end
          REG_KEY_LOW: begin key_lo = cfg_data; expand_keys(); end
          REG_IV_HIGH: begin iv_hi = cfg_data; chain[127:64] = cfg_data; end
          REG_IV_LOW: begin iv_lo = cfg_data; chain[63:0] = cfg_data; end
          REG_IV_PER_PACKET: iv_reload = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) descramble_byte(in_byte);
      if (out_valid && !out_stall) check_byte();
    end
  end

endmodule

// ===== verif/ts_aes_cbc_descrambler_unit_tb.sv =====
// Testbench top: drives packets and register writes into the descrambler and gives the verdict.
`timescale 1ns / 100ps
module ts_aes_cbc_descrambler_unit_tb;
  import tsd_pkg::*;

  localparam int IDLE_LIMIT  = 5000;
  localparam int DRAIN_WAIT  = 24;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_KEY_HIGH;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_decrypted, out_last, packet_done;
  logic [2:0]  packet_status;
  int          errors, pending;
  int          idle_cycles = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b0;
  int          stall_mode = 0;

  ts_aes_cbc_descrambler_unit dut (.*);
  ts_aes_cbc_descrambler_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 15) < 11);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (gaps_on && burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    burst_left--;
    do @(posedge clk); while (in_stall);
  endtask

  // header: sync, pid, scrambling bits, adaptation field control, adaptation length
  task automatic send_packet(input logic [7:0] sync, input logic [12:0] pid,
                             input logic [1:0] scr, input logic [1:0] afc,
                             input logic [7:0] aflen);
    logic [7:0] b;
    for (int i = 0; i < PACKET_BYTES; i++) begin
      b = $urandom_range(0, 255);
      case (i)
        0: b = sync;
        1: b = {b[7:5], pid[12:8]};
        2: b = pid[7:0];
        3: b = {scr, afc, b[3:0]};
        4: if (afc[1]) b = aflen;
        default: ;
      endcase
      send_byte(b);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic load_config(input logic [63:0] kh, input logic [63:0] kl,
                             input logic [63:0] ih, input logic [63:0] il,
                             input logic per);
    drain();
    write_reg(REG_KEY_HIGH, kh);
    write_reg(REG_KEY_LOW, kl);
    write_reg(REG_IV_HIGH, ih);
    write_reg(REG_IV_LOW, il);
    write_reg(REG_IV_PER_PACKET, {63'd0, per});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // scrambled packet, no adaptation field, reset settings, light output stalls
    stall_mode = 1;
    send_packet(SYNC_BYTE, 13'h0100, 2'b11, 2'b01, 8'd0);

    // fresh key and IV reloaded per packet, bursty input, heavy output stalls
    load_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, 1'b1);
    gaps_on = 1'b1;
    stall_mode = 2;
    send_packet(SYNC_BYTE, 13'h0042, 2'b10, 2'b11, 8'($urandom_range(0, 40)));

    drain();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
